### rtl/lmsanc_pkg.sv
// Shared constants, command/status structs and controller state type for the LMS canceller.
package lmsanc_pkg;

    // Filter length and derived index width
    localparam int TAPS  = 300;
    localparam int IDX_W = $clog2(TAPS);

    // Sample, weight and accumulator widths
    localparam int SMP_W = 16;
    localparam int WGT_W = 40;
    localparam int ACC_W = 64;
    localparam int MU_W  = 6;

    // Step size after reset
    localparam logic [MU_W-1:0] MU_RESET = 6'd30;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_MAC_DRAIN,
        ST_FINISH,
        ST_OUT,
        ST_UPD,
        ST_UPD_DRAIN
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic mac_step;
        logic upd_step;
        logic finish;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic k_last;
        logic busy;
    } sts_t;

endpackage

### rtl/lmsanc_ctrl.sv
// Controller state machine: sequences clearing, filter pass, output and weight update.
module lmsanc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  lmsanc_pkg::sts_t   sts,
    output lmsanc_pkg::cmd_t   cmd
);
    import lmsanc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.k_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (sts.k_last)
                    state_next = ST_MAC_DRAIN;
            end
            ST_MAC_DRAIN:
            begin
                if (!sts.busy)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (sts.k_last)
                    state_next = ST_UPD_DRAIN;
            end
            ST_UPD_DRAIN:
            begin
                if (!sts.busy)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_MAC:
            begin
                cmd.mac_step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
            end
            ST_OUT:
            begin
                cmd.out_load = out_free;
            end
            ST_UPD:
            begin
                cmd.upd_step = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Hold the result valid until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/lmsanc_dp.sv
// Datapath: delay-line and weight memories, shared MAC, update pipeline and result registers.
module lmsanc_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lmsanc_pkg::cmd_t                    cmd,
    input  logic signed [lmsanc_pkg::SMP_W-1:0] in_ref,
    input  logic signed [lmsanc_pkg::SMP_W-1:0] in_primary,
    input  logic                                cfg_we,
    input  logic [lmsanc_pkg::MU_W-1:0]         cfg_data,
    output lmsanc_pkg::sts_t                    sts,
    output logic signed [lmsanc_pkg::SMP_W-1:0] out_error,
    output logic signed [lmsanc_pkg::SMP_W-1:0] out_filter
);
    import lmsanc_pkg::*;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TAPS - 1);
    localparam logic signed [56:0] W_MAX57 = 57'sd549755813887;
    localparam logic signed [56:0] W_MIN57 = -57'sd549755813888;
    localparam logic signed [40:0] S_MAX41 = 41'sd32767;
    localparam logic signed [40:0] S_MIN41 = -41'sd32768;
    localparam logic signed [39:0] S_MAX40 = 40'sd32767;
    localparam logic signed [39:0] S_MIN40 = -40'sd32768;

    // Memories
    logic signed [SMP_W-1:0] hist_mem [TAPS];
    logic signed [WGT_W-1:0] wgt_mem  [TAPS];

    // Control registers
    logic [MU_W-1:0]  mu_shift_reg;
    logic [IDX_W-1:0] k_reg,    k_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] hptr_reg, hptr_next;
    logic             mv1_reg, mv2_reg;
    logic             uv1_reg, uv2_reg, uv3_reg;

    // Payload registers
    logic signed [SMP_W-1:0] hist_rd_reg;
    logic signed [WGT_W-1:0] wgt_rd_reg;
    logic signed [SMP_W-1:0] primary_reg;
    logic signed [55:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [SMP_W-1:0] err_reg, err_next;
    logic signed [SMP_W-1:0] y_reg,   y_next;
    logic signed [31:0]      p_reg;
    logic signed [WGT_W-1:0] wq1_reg, wq2_reg;
    logic signed [55:0]      delta_reg;
    logic [IDX_W-1:0]        ua1_reg, ua2_reg, ua3_reg;
    logic signed [SMP_W-1:0] out_error_reg, out_filter_reg;

    // Intermediate signals
    logic                    step;
    logic [IDX_W-1:0]        head_dec;
    logic signed [55:0]      prod_next;
    logic signed [64:0]      acc_sum;
    logic signed [39:0]      shifted;
    logic signed [40:0]      err_full;
    logic signed [31:0]      p_next;
    logic signed [55:0]      p_scaled;
    logic signed [55:0]      delta_next;
    logic signed [56:0]      wsum;
    logic signed [WGT_W-1:0] wnew;

    assign step     = cmd.mac_step || cmd.upd_step || cmd.clear_step;
    assign head_dec = (head_reg == '0) ? IDX_LAST : head_reg - 1'b1;

    assign sts.k_last = (k_reg == IDX_LAST);
    assign sts.busy   = mv1_reg || mv2_reg || uv1_reg || uv2_reg || uv3_reg;

    // Advance tap index and delay-line pointer; on the last tap k returns to zero and the pointer to the head
    always_comb
    begin
        k_next    = k_reg;
        head_next = head_reg;
        hptr_next = hptr_reg;
        if (cmd.accept)
        begin
            head_next = head_dec;
            hptr_next = head_dec;
            k_next    = '0;
        end
        else if (step)
        begin
            if (k_reg == IDX_LAST)
            begin
                k_next    = '0;
                hptr_next = head_reg;
            end
            else
            begin
                k_next    = k_reg + 1'b1;
                hptr_next = (hptr_reg == IDX_LAST) ? '0 : hptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_shift_reg <= MU_RESET;
            k_reg        <= '0;
            head_reg     <= '0;
            hptr_reg     <= '0;
            mv1_reg      <= 1'b0;
            mv2_reg      <= 1'b0;
            uv1_reg      <= 1'b0;
            uv2_reg      <= 1'b0;
            uv3_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mu_shift_reg <= cfg_data;
            k_reg    <= k_next;
            head_reg <= head_next;
            hptr_reg <= hptr_next;
            mv1_reg  <= cmd.mac_step;
            mv2_reg  <= mv1_reg;
            uv1_reg  <= cmd.upd_step;
            uv2_reg  <= uv1_reg;
            uv3_reg  <= uv2_reg;
        end
    end

    // Delay-line memory: clear, insert newest sample, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
            hist_mem[k_reg] <= '0;
        else if (cmd.accept)
            hist_mem[head_dec] <= in_ref;
        hist_rd_reg <= hist_mem[hptr_reg];
    end

    // Weight memory: clear, write back updated weight, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
            wgt_mem[k_reg] <= '0;
        else if (uv3_reg)
            wgt_mem[ua3_reg] <= wnew;
        wgt_rd_reg <= wgt_mem[k_reg];
    end

    // Filter pass: multiply, then saturating accumulate
    assign prod_next = hist_rd_reg * wgt_rd_reg;
    assign acc_sum   = {acc_reg[ACC_W-1], acc_reg} + {{9{prod_reg[55]}}, prod_reg};

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.accept)
            acc_next = '0;
        else if (mv2_reg)
        begin
            if (acc_sum[64] != acc_sum[63])
                acc_next = acc_sum[64] ? {1'b1, {(ACC_W-1){1'b0}}}
                                       : {1'b0, {(ACC_W-1){1'b1}}};
            else
                acc_next = acc_sum[ACC_W-1:0];
        end
    end

    // Error and filter output, saturated to 16 bits
    assign shifted  = acc_reg[63:24];
    assign err_full = {{25{primary_reg[SMP_W-1]}}, primary_reg} - {shifted[39], shifted};

    always_comb
    begin
        err_next = err_reg;
        y_next   = y_reg;
        if (cmd.finish)
        begin
            if (err_full > S_MAX41)
                err_next = 16'sh7fff;
            else if (err_full < S_MIN41)
                err_next = -16'sh8000;
            else
                err_next = err_full[SMP_W-1:0];
            if (shifted > S_MAX40)
                y_next = 16'sh7fff;
            else if (shifted < S_MIN40)
                y_next = -16'sh8000;
            else
                y_next = shifted[SMP_W-1:0];
        end
    end

    // Weight update: x*e, scale by 2^24 and shift by mu, add and saturate
    assign p_next     = hist_rd_reg * err_reg;
    assign p_scaled   = {p_reg, 24'd0};
    assign delta_next = p_scaled >>> mu_shift_reg;
    assign wsum       = {{17{wq2_reg[WGT_W-1]}}, wq2_reg} + {delta_reg[55], delta_reg};

    always_comb
    begin
        if (wsum > W_MAX57)
            wnew = {1'b0, {(WGT_W-1){1'b1}}};
        else if (wsum < W_MIN57)
            wnew = {1'b1, {(WGT_W-1){1'b0}}};
        else
            wnew = wsum[WGT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            primary_reg <= in_primary;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        err_reg   <= err_next;
        y_reg     <= y_next;
        p_reg     <= p_next;
        wq1_reg   <= wgt_rd_reg;
        wq2_reg   <= wq1_reg;
        delta_reg <= delta_next;
        ua1_reg   <= k_reg;
        ua2_reg   <= ua1_reg;
        ua3_reg   <= ua2_reg;
        if (cmd.out_load)
        begin
            out_error_reg  <= err_reg;
            out_filter_reg <= y_reg;
        end
    end

    assign out_error  = out_error_reg;
    assign out_filter = out_filter_reg;

endmodule

### rtl/lms_adaptive_noise_canceller.sv
// Sequence: one item at a time; 300 filter products and 300 weight updates
// through the shared MAC, each pass followed by a pipeline drain, then error, output and idle.
// Output: the result is offered once the filter pass, its drain and the error stage are done,
// unless the previous result is still waiting to be taken.
// Reset: asynchronous, active low; a clearing pass over all 300 taps then zeroes the
// delay line and weights, and no item is accepted until it ends.
module lms_adaptive_noise_canceller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] ref_sample, [31:16] primary_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] error_sample, [31:16] filter_output
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data        // mu_shift
);
    import lmsanc_pkg::*;

    cmd_t                    cmd;
    sts_t                    sts;
    logic signed [SMP_W-1:0] error_sample;
    logic signed [SMP_W-1:0] filter_output;

    assign cfg_ready = 1'b1;

    lmsanc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lmsanc_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_ref     (s_axis_tdata[15:0]),
        .in_primary (s_axis_tdata[31:16]),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .sts        (sts),
        .out_error  (error_sample),
        .out_filter (filter_output)
    );

    assign m_axis_tdata = {filter_output, error_sample};

    // One item at a time: no new item right after one is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item accepted while previous one still in work");

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result register loaded while occupied");

    // Filter pipeline must be drained before the error is formed
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !sts.busy)
        else $error("error formed before accumulation finished");

endmodule

### test/tb_lms_adaptive_noise_canceller.sv
// Self-checking testbench for the LMS adaptive noise canceller: directed table, then random phases.
module tb_lms_adaptive_noise_canceller;

    import lmsanc_pkg::*;

    typedef logic signed [SMP_W-1:0] sample_t;
    typedef logic signed [WGT_W-1:0] weight_t;

    // One cancelled sample as it leaves the block
    typedef struct packed {
        sample_t err;
        sample_t est;
    } cancel_t;

    // One directed item; err and est only count where typed is set
    typedef struct packed {
        sample_t noise;
        sample_t primary;
        logic    typed;
        sample_t err;
        sample_t est;
    } row_t;

    localparam int     NUM_DIRECTED    = 16;
    localparam int     NUM_PHASES      = 12;
    localparam int     PLANNED_PHASES  = 10;
    localparam int     ITEMS_PER_PHASE = 80;
    localparam int     SETTLE_CYCLES   = 340;
    localparam int     CYCLE_LIMIT     = 8000000;
    localparam longint W_TOP           = (64'sd1 <<< (WGT_W - 1)) - 1;
    localparam longint W_BOT           = -(64'sd1 <<< (WGT_W - 1));
    localparam longint S_TOP           = 64'sd32767;
    localparam longint S_BOT           = -64'sd32768;

    // Weights stay zero while the error is zero, so the first rows read off directly
    localparam row_t DIRECTED [NUM_DIRECTED] = '{
        '{16'sh0000, 16'sh0000, 1'b1, 16'sh0000, 16'sh0000},
        '{16'sh7FFF, 16'sh0000, 1'b1, 16'sh0000, 16'sh0000},
        '{16'sh8000, 16'sh0000, 1'b1, 16'sh0000, 16'sh0000},
        '{16'sh0001, 16'sh0000, 1'b1, 16'sh0000, 16'sh0000},
        '{16'shFFFF, 16'sh0000, 1'b1, 16'sh0000, 16'sh0000},
        '{16'sh0000, 16'sh7FFF, 1'b1, 16'sh7FFF, 16'sh0000},
        '{16'sh0000, 16'sh8000, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh8000, 16'sh8000, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh7FFF, 16'sh7FFF, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh5555, 16'shAAAA, 1'b0, 16'sh0000, 16'sh0000},
        '{16'shAAAA, 16'sh5555, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh8000, 16'sh7FFF, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh7FFF, 16'sh8000, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
        '{16'sh0123, 16'shFEDC, 1'b0, 16'sh0000, 16'sh0000},
        '{16'shFFFF, 16'sh0001, 1'b0, 16'sh0000, 16'sh0000}
    };

    // Step sizes per phase: mid range, both extremes and the top of the useful range
    localparam logic [MU_W-1:0] STEP_PLAN [PLANNED_PHASES] = '{
        6'd30, 6'd27, 6'd33, 6'd63, 6'd48, 6'd24, 6'd36, 6'd29, 6'd0, 6'd12
    };

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;    // [15:0] ref_sample, [31:16] primary_sample
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [15:0] error_sample, [31:16] filter_output
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data      = '0;    // mu_shift

    // Predictor state
    sample_t         delay_line [TAPS];
    weight_t         tap_wt     [TAPS];
    logic [MU_W-1:0] step_shift = MU_RESET;
    sample_t         prev_noise = '0;

    cancel_t pending_cancel [$];
    cancel_t due;
    int      fail_count  = 0;
    int      cycle_count = 0;
    int      burst_left  = 0;
    int      hold_cycles = 0;

    lms_adaptive_noise_canceller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Shift in the new noise sample, filter, form the error, then adapt every weight
    function automatic cancel_t lms_predict(input sample_t x, input sample_t d);
        longint  acc;
        longint  prod;
        longint  sum;
        longint  shifted;
        longint  err_w;
        longint  w;
        cancel_t r;
        int      k;
        acc = 0;
        for (k = TAPS - 1; k > 0; k--)
            delay_line[k] = delay_line[k - 1];
        delay_line[0] = x;
        // Accumulate with saturation at the 64-bit limits
        for (k = 0; k < TAPS; k++)
        begin
            prod = longint'(delay_line[k]) * longint'(tap_wt[k]);
            sum  = acc + prod;
            if (prod > 0 && sum < acc)
                sum = 64'sh7FFF_FFFF_FFFF_FFFF;
            else if (prod < 0 && sum > acc)
                sum = 64'sh8000_0000_0000_0000;
            acc = sum;
        end
        shifted = acc >>> 24;
        err_w   = clip(longint'(d) - shifted, S_BOT, S_TOP);
        r.est   = sample_t'(clip(shifted, S_BOT, S_TOP));
        r.err   = sample_t'(err_w);
        // Adapt weights with the saturated error, rounding towards minus infinity
        for (k = 0; k < TAPS; k++)
        begin
            prod      = longint'(delay_line[k]) * err_w * 64'sd16777216;
            w         = longint'(tap_wt[k]) + (prod >>> step_shift);
            tap_wt[k] = weight_t'(clip(w, W_BOT, W_TOP));
        end
        return r;
    endfunction

    function automatic sample_t pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'shFFFF;
            3:       return 16'sh0001;
            default: return 16'sh0000;
        endcase
    endfunction

    // Mostly primary = speech plus filtered noise at moderate level; the rest raw or extreme
    task automatic draw_sample(output sample_t x, output sample_t d);
        sample_t raw;
        sample_t speech;
        longint  mix;
        case ($urandom_range(0, 19))
            0, 1, 2:
            begin
                x = sample_t'($urandom);
                d = sample_t'($urandom);
            end
            3, 4:
            begin
                x = pick_extreme();
                d = pick_extreme();
            end
            default:
            begin
                raw    = sample_t'($urandom);
                x      = raw >>> $urandom_range(2, 9);
                raw    = sample_t'($urandom);
                speech = raw >>> $urandom_range(5, 12);
                mix    = ((longint'(x) * 3 + longint'(prev_noise)) >>> 2) + longint'(speech);
                d      = sample_t'(clip(mix, S_BOT, S_TOP));
            end
        endcase
        prev_noise = x;
    endtask

    // Offer one item, predict on acceptance, then hold valid or drop it for a gap
    task automatic send_sample(input sample_t x, input sample_t d, input logic typed,
                               input cancel_t typed_val, input logic more);
        cancel_t predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {d, x};
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        predicted = lms_predict(x, d);
        pending_cancel.push_back(typed ? typed_val : predicted);
        if (more && burst_left != 0)
            burst_left--;
        else
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            if (more)
            begin
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(1, 700)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                burst_left = $urandom_range(0, 8);
            end
        end
    endtask

    // Hold off until every result is in and the weight update has finished
    task automatic wait_idle();
        while (pending_cancel.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_step(input logic [MU_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid  <= 1'b0;
        step_shift = v;
    endtask

    // Receiver: random ready level held for random stretches, now and then long stalls
    always @(posedge clk)
    begin
        if (hold_cycles != 0)
            hold_cycles <= hold_cycles - 1;
        else
        begin
            m_axis_tready <= ($urandom_range(0, 2) != 0);
            case ($urandom_range(0, 9))
                0:          hold_cycles <= $urandom_range(0, 400);
                1, 2, 3:    hold_cycles <= $urandom_range(0, 40);
                default:    hold_cycles <= $urandom_range(0, 3);
            endcase
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_cancel.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, got %h", $time, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                due = pending_cancel.pop_front();
                if ($signed(m_axis_tdata[15:0]) != due.err)
                begin
                    $display("%0t: error_sample expected %0d got %0d", $time, due.err,
                             $signed(m_axis_tdata[15:0]));
                    fail_count++;
                end
                if ($signed(m_axis_tdata[31:16]) != due.est)
                begin
                    $display("%0t: filter_output expected %0d got %0d", $time, due.est,
                             $signed(m_axis_tdata[31:16]));
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[lms_adaptive_noise_canceller] ERROR");
            $finish;
        end
    end

    initial
    begin
        int      i;
        int      p;
        int      n;
        sample_t x;
        sample_t d;
        for (i = 0; i < TAPS; i++)
        begin
            delay_line[i] = '0;
            tap_wt[i]     = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows at the reset step size
        for (i = 0; i < NUM_DIRECTED; i++)
            send_sample(DIRECTED[i].noise, DIRECTED[i].primary, DIRECTED[i].typed,
                        {DIRECTED[i].err, DIRECTED[i].est}, i != NUM_DIRECTED - 1);
        wait_idle();

        // Random phases, one step size each, written while the block is idle
        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p < PLANNED_PHASES)
                write_step(STEP_PLAN[p]);
            else
                write_step(MU_W'($urandom_range(0, 63)));
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                draw_sample(x, d);
                send_sample(x, d, 1'b0, '0, n != ITEMS_PER_PHASE - 1);
            end
            wait_idle();
        end

        if (fail_count == 0 && pending_cancel.size() == 0)
            $display("[lms_adaptive_noise_canceller] OK");
        else
            $display("[lms_adaptive_noise_canceller] ERROR");
        $finish;
    end

endmodule
